// File: hdl/ioj_pkg.sv
package ioj_pkg;

  // Width of the result index field on the output channel.
  localparam int unsigned IDX_BITS = 6;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned CFG_IDX_BITS = 3;

  // Input word modes.
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Result word status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_MATCH   = 3'd0,
    ST_NOMATCH = 3'd1,
    ST_LOADED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MATCH_MODE      = 3'd0,
    REG_QUERY_RATE_ON   = 3'd1,
    REG_QUERY_RATE      = 3'd2,
    REG_SUBJECT_RATE_ON = 3'd3,
    REG_SUBJECT_RATE    = 3'd4
  } reg_e;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;
    logic clear;
    logic calc_thr;
  } cell_ctrl_t;

endpackage

// File: hdl/ioj_in_if.sv
interface ioj_in_if #(
  parameter int unsigned COORD_BITS = 30
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            mode;
  logic [COORD_BITS-1:0] item_start;
  logic [COORD_BITS-1:0] item_end;

  modport source (output valid, mode, item_start, item_end, input ready);
  modport sink   (input valid, mode, item_start, item_end, output ready);
endinterface

// File: hdl/ioj_out_if.sv
interface ioj_out_if;
  logic                               valid;
  logic                               ready;
  logic [ioj_pkg::STATUS_BITS-1:0]    status;
  logic [ioj_pkg::IDX_BITS-1:0]       match_index;
  logic                               last;

  modport source (output valid, status, match_index, last, input ready);
  modport sink   (input valid, status, match_index, last, output ready);
endinterface

// File: hdl/interval_overlap_join.sv
// Channel  Dir  Fields
// in_w     in   mode, item_start, item_end
// out_w    out  status, match_index, last
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// A load or clear registers its result word when the input word is taken; an unused mode gives no result word.
// A query computes the thresholds, then the compare in every cell at once, then drains
// one result word per match, or a no-match word, as the output takes them.
// Reset empties the table at once; no clearing pass is needed.
// A stalled output holds the result word; a new input word is taken as it leaves.
module interval_overlap_join #(
  parameter int unsigned TABLE_DEPTH    = 64,
  parameter int unsigned COORD_BITS     = 30,
  parameter int unsigned RATE_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  ioj_in_if.sink                               in_w,
  ioj_out_if.source                            out_w,
  input  logic                                 cfg_we_i,
  input  logic [ioj_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [RATE_FRAC_BITS+1:0]            cfg_data_i
);

  localparam int unsigned RATE_W = RATE_FRAC_BITS + 2;
  localparam int unsigned THR_W  = COORD_BITS + 2;
  localparam int unsigned PROD_W = COORD_BITS + RATE_W;
  localparam int unsigned IW     = $clog2(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_THR,
    S_CMP,
    S_DRAIN
  } state_e;

  state_e                state_q;
  logic                  match_mode_q, q_on_q, s_on_q;
  logic [RATE_W-1:0]     q_rate_q, s_rate_q;
  logic [COORD_BITS-1:0] qs_q, qe_q;
  logic [THR_W-1:0]      qthr_q;
  logic [TABLE_DEPTH-1:0] pend_q, hits, cell_vld;
  logic                  out_vld_q, out_last_q;
  logic [ioj_pkg::STATUS_BITS-1:0] out_status_q;
  logic [ioj_pkg::IDX_BITS-1:0]    out_idx_q;

  logic                  out_free, in_acc, out_set;
  ioj_pkg::cell_ctrl_t   ctrl;
  logic [COORD_BITS-1:0] bus_start, bus_end;
  logic [COORD_BITS-1:0] qlen;
  logic [PROD_W-1:0]     qprod;
  logic [IW-1:0]         low_idx;
  logic [TABLE_DEPTH-1:0] pend_rest;

  logic [COORD_BITS-1:0] c_start [TABLE_DEPTH];
  logic [COORD_BITS-1:0] c_end   [TABLE_DEPTH];

  assign out_free = !out_vld_q || out_w.ready;
  assign in_w.ready = (state_q == S_IDLE) && out_free;
  assign in_acc = in_w.valid && in_w.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_mode_q <= 1'b0;
      q_on_q       <= 1'b1;
      q_rate_q     <= RATE_W'(1) << (RATE_FRAC_BITS - 1);
      s_on_q       <= 1'b1;
      s_rate_q     <= RATE_W'(1) << (RATE_FRAC_BITS - 1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ioj_pkg::REG_MATCH_MODE:      match_mode_q <= cfg_data_i[0];
        ioj_pkg::REG_QUERY_RATE_ON:   q_on_q       <= cfg_data_i[0];
        ioj_pkg::REG_QUERY_RATE:      q_rate_q     <= cfg_data_i;
        ioj_pkg::REG_SUBJECT_RATE_ON: s_on_q       <= cfg_data_i[0];
        ioj_pkg::REG_SUBJECT_RATE:    s_rate_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Commands and the shared coordinate bus for the cells.
  always_comb begin
    ctrl.load     = in_acc && (in_w.mode == ioj_pkg::MODE_LOAD) && !cell_vld[TABLE_DEPTH-1];
    ctrl.clear    = in_acc && (in_w.mode == ioj_pkg::MODE_CLEAR);
    ctrl.calc_thr = (state_q == S_THR);
    bus_start     = (state_q == S_IDLE) ? in_w.item_start : qs_q;
    bus_end       = (state_q == S_IDLE) ? in_w.item_end : qe_q;
    qlen          = (qe_q >= qs_q) ? (qe_q - qs_q) : '0;
    qprod         = PROD_W'(qlen) * PROD_W'(q_rate_q);
  end

  // The head cell sees a filled neighbor that starts at zero.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic                  pv;
    logic [COORD_BITS-1:0] ps, pe;
    if (g == 0) begin : g_head
      assign pv = 1'b1;
      assign ps = '0;
      assign pe = '0;
    end else begin : g_link
      assign pv = cell_vld[g-1];
      assign ps = c_start[g-1];
      assign pe = c_end[g-1];
    end
    ioj_cell #(
      .COORD_BITS     (COORD_BITS),
      .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_vld_i   (pv),
      .prev_start_i (ps),
      .prev_end_i   (pe),
      .bus_start_i  (bus_start),
      .bus_end_i    (bus_end),
      .qthr_i       (qthr_q),
      .qinf_i       (!q_on_q),
      .srate_i      (s_rate_q),
      .s_on_i       (s_on_q),
      .any_mode_i   (match_mode_q),
      .vld_o        (cell_vld[g]),
      .start_o      (c_start[g]),
      .end_o        (c_end[g]),
      .hit_o        (hits[g])
    );
  end

  // Lowest pending match goes out first.
  always_comb begin
    low_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        low_idx = IW'(i);
      end
    end
    pend_rest = pend_q & (pend_q - TABLE_DEPTH'(1));
  end

  // A new result word is loaded after a load or clear, and on each drain step.
  always_comb begin
    out_set = (in_acc && ((in_w.mode == ioj_pkg::MODE_LOAD) ||
                          (in_w.mode == ioj_pkg::MODE_CLEAR))) ||
              ((state_q == S_DRAIN) && out_free);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qs_q <= in_w.item_start;
      qe_q <= in_w.item_end;
    end
    if (state_q == S_THR) begin
      qthr_q <= qprod[PROD_W-1:RATE_FRAC_BITS];
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_q       <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= ioj_pkg::ST_NOMATCH;
      out_idx_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_set) begin
        out_vld_q <= 1'b1;
      end else if (out_w.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            out_idx_q  <= '0;
            out_last_q <= 1'b1;
            unique case (in_w.mode)
              ioj_pkg::MODE_LOAD: begin
                out_status_q <= cell_vld[TABLE_DEPTH-1] ? ioj_pkg::ST_FULL
                                                        : ioj_pkg::ST_LOADED;
              end
              ioj_pkg::MODE_CLEAR: begin
                out_status_q <= ioj_pkg::ST_CLEARED;
              end
              ioj_pkg::MODE_QUERY: state_q <= S_THR;
              default: ;
            endcase
          end
        end
        S_THR: state_q <= S_CMP;
        S_CMP: begin
          pend_q  <= hits;
          state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (out_free) begin
            if (pend_q == '0) begin
              out_status_q <= ioj_pkg::ST_NOMATCH;
              out_idx_q    <= '0;
              out_last_q   <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              out_status_q <= ioj_pkg::ST_MATCH;
              out_idx_q    <= ioj_pkg::IDX_BITS'(low_idx);
              out_last_q   <= (pend_rest == '0);
              pend_q       <= pend_rest;
              if (pend_rest == '0) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_w.valid       = out_vld_q;
  assign out_w.status      = out_status_q;
  assign out_w.match_index = out_idx_q;
  assign out_w.last        = out_last_q;

  // The table is always filled from the front.
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, cell_vld} + (TABLE_DEPTH + 1)'(1)))
    else $error("cell valid bits are not a prefix");

  // A reported match index lies within the table.
  a_match_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q == ioj_pkg::ST_MATCH) |-> (out_idx_q < TABLE_DEPTH))
    else $error("match index beyond table");

  // No input word is taken while a query is in progress.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_w.ready)
    else $error("input ready during query");

  // The drain ends with a last word.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && out_free && pend_rest == '0) |=> (out_last_q && out_vld_q))
    else $error("drain ended without last");

endmodule

// File: hdl/ioj_cell.sv
module ioj_cell #(
  parameter int unsigned COORD_BITS     = 30,
  parameter int unsigned RATE_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ioj_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        prev_vld_i,
  input  logic [COORD_BITS-1:0]       prev_start_i,
  input  logic [COORD_BITS-1:0]       prev_end_i,
  input  logic [COORD_BITS-1:0]       bus_start_i,
  input  logic [COORD_BITS-1:0]       bus_end_i,
  input  logic [COORD_BITS+1:0]       qthr_i,
  input  logic                        qinf_i,
  input  logic [RATE_FRAC_BITS+1:0]   srate_i,
  input  logic                        s_on_i,
  input  logic                        any_mode_i,
  output logic                        vld_o,
  output logic [COORD_BITS-1:0]       start_o,
  output logic [COORD_BITS-1:0]       end_o,
  output logic                        hit_o
);

  localparam int unsigned THR_W  = COORD_BITS + 2;
  localparam int unsigned PROD_W = COORD_BITS + RATE_FRAC_BITS + 2;

  logic                  vld_q, vld_d;
  logic [COORD_BITS-1:0] start_q, start_d, end_q, end_d;
  logic [THR_W-1:0]      sthr_q;
  logic [COORD_BITS-1:0] len;
  logic [PROD_W-1:0]     prod;
  logic                  prev_gt, self_gt;
  logic [COORD_BITS-1:0] lo, hi, ov;
  logic [THR_W-1:0]      thr;
  logic                  rate_hit;

  // Sorted insert: shift right where the left neighbor starts later.
  // The new word lands only in the cell right after the last start that is not larger,
  // so it needs a filled left neighbor.
  always_comb begin
    prev_gt = prev_vld_i && (prev_start_i > bus_start_i);
    self_gt = !vld_q || (start_q > bus_start_i);
    vld_d   = vld_q;
    start_d = start_q;
    end_d   = end_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctrl_i.load) begin
      if (prev_gt) begin
        vld_d   = 1'b1;
        start_d = prev_start_i;
        end_d   = prev_end_i;
      end else if (self_gt && prev_vld_i) begin
        vld_d   = 1'b1;
        start_d = bus_start_i;
        end_d   = bus_end_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

  // Subject threshold, registered ahead of the compare.
  always_comb begin
    len  = (end_q >= start_q) ? (end_q - start_q) : '0;
    prod = PROD_W'(len) * PROD_W'(srate_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.calc_thr) begin
      sthr_q <= prod[PROD_W-1:RATE_FRAC_BITS];
    end
  end

  // Overlap compare against the query on the bus.
  always_comb begin
    lo = (start_q > bus_start_i) ? start_q : bus_start_i;
    hi = (end_q < bus_end_i) ? end_q : bus_end_i;
    ov = hi - lo;
    if (qinf_i) begin
      thr = sthr_q;
    end else if (!s_on_i) begin
      thr = qthr_i;
    end else begin
      thr = (qthr_i < sthr_q) ? qthr_i : sthr_q;
    end
    rate_hit = !(qinf_i && !s_on_i) && (hi >= lo) && (THR_W'(ov) >= thr);
    hit_o = vld_q && (start_q <= bus_end_i) &&
            (any_mode_i ? (end_q >= bus_start_i) : rate_hit);
  end

  assign vld_o   = vld_q;
  assign start_o = start_q;
  assign end_o   = end_q;

endmodule

// File: sim/interval_overlap_join_test.sv
`timescale 1ns / 1ps

module interval_overlap_join_test;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CBITS = 30;
  localparam int unsigned FBITS = 16;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 108;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] index;
    logic       last;
  } result_t;

  typedef struct {
    ioj_pkg::mode_e   mode;
    logic [CBITS-1:0] qs;
    logic [CBITS-1:0] qe;
    bit               typed;
    result_t          want;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [ioj_pkg::CFG_IDX_BITS-1:0] cfg_idx_i;
  logic [FBITS+1:0] cfg_data_i;

  ioj_in_if #(.COORD_BITS(CBITS)) in_w ();
  ioj_out_if out_w ();

  interval_overlap_join #(
    .TABLE_DEPTH(DEPTH),
    .COORD_BITS(CBITS),
    .RATE_FRAC_BITS(FBITS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_w(in_w),
    .out_w(out_w),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the table and the register file.
  logic [CBITS-1:0] tbl_start [DEPTH];
  logic [CBITS-1:0] tbl_end [DEPTH];
  int unsigned tbl_count;
  bit sh_any_mode;
  bit sh_qon;
  bit sh_son;
  logic [FBITS+1:0] sh_qrate;
  logic [FBITS+1:0] sh_srate;

  result_t pending_results[$];
  result_t predicted_first;
  int unsigned errors;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned match_words;
  int unsigned full_hits;
  int unsigned idle_cycles;
  bit in_idle_on;
  bit out_idle_on;
  bit long_hold;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Append one expected result word at the tail of the queue.
  function automatic void add_expected(result_t w);
    pending_results.insert(pending_results.size(), w);
  endfunction

  // Threshold of one interval; an all-ones value stands for infinite.
  function automatic logic [63:0] overlap_threshold(logic [CBITS-1:0] s, logic [CBITS-1:0] e,
                                                     bit on, logic [FBITS+1:0] rate);
    logic [63:0] len;
    if (!on) return '1;
    len = (e >= s) ? 64'(e - s) : 64'd0;
    return (len * 64'(rate)) >> FBITS;
  endfunction

  // Compute the result words of one input word and update the shadow table.
  task automatic predict_join(ioj_pkg::mode_e mode, logic [CBITS-1:0] qs,
                              logic [CBITS-1:0] qe);
    int unsigned pos;
    int unsigned hits;
    logic [63:0] qthr;
    logic [63:0] sthr;
    logic [63:0] thr;
    longint lo;
    longint hi;
    bit hit;
    hits = 0;
    case (mode)
      ioj_pkg::MODE_LOAD: begin
        if (tbl_count >= DEPTH) begin
          add_expected('{ioj_pkg::ST_FULL, 6'd0, 1'b1});
          full_hits++;
        end else begin
          pos = tbl_count;
          while (pos > 0 && tbl_start[pos-1] > qs) begin
            tbl_start[pos] = tbl_start[pos-1];
            tbl_end[pos] = tbl_end[pos-1];
            pos--;
          end
          tbl_start[pos] = qs;
          tbl_end[pos] = qe;
          tbl_count++;
          add_expected('{ioj_pkg::ST_LOADED, 6'd0, 1'b1});
        end
      end
      ioj_pkg::MODE_CLEAR: begin
        tbl_count = 0;
        add_expected('{ioj_pkg::ST_CLEARED, 6'd0, 1'b1});
      end
      ioj_pkg::MODE_QUERY: begin
        qthr = overlap_threshold(qs, qe, sh_qon, sh_qrate);
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_start[i] > qe) break;
          if (sh_any_mode) begin
            hit = tbl_end[i] >= qs;
          end else begin
            sthr = overlap_threshold(tbl_start[i], tbl_end[i], sh_son, sh_srate);
            thr = (qthr < sthr) ? qthr : sthr;
            lo = (tbl_start[i] > qs) ? tbl_start[i] : qs;
            hi = (tbl_end[i] < qe) ? tbl_end[i] : qe;
            hit = (thr != '1) && (hi - lo >= 0) && (64'(hi - lo) >= thr);
          end
          if (hit) begin
            add_expected('{ioj_pkg::ST_MATCH, 6'(i), 1'b0});
            hits++;
          end
        end
        if (hits == 0) add_expected('{ioj_pkg::ST_NOMATCH, 6'd0, 1'b1});
        else pending_results[$].last = 1'b1;
        match_words += hits;
      end
      default: begin
      end
    endcase
  endtask

  // Write one register while the block is idle, then lower the write enable and update the shadow copy.
  task automatic write_reg(ioj_pkg::reg_e idx, logic [FBITS+1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      ioj_pkg::REG_MATCH_MODE: sh_any_mode = value[0];
      ioj_pkg::REG_QUERY_RATE_ON: sh_qon = value[0];
      ioj_pkg::REG_QUERY_RATE: sh_qrate = value;
      ioj_pkg::REG_SUBJECT_RATE_ON: sh_son = value[0];
      ioj_pkg::REG_SUBJECT_RATE: sh_srate = value;
      default: begin
      end
    endcase
  endtask

  // Offer one word, with random idling ahead of it, until it is taken.
  // Valid stays up after the handshake; idling before the next word or a drain wait lowers it.
  task automatic send_word(ioj_pkg::mode_e mode, logic [CBITS-1:0] qs, logic [CBITS-1:0] qe);
    int unsigned base;
    while (in_idle_on && $urandom_range(99) < 21) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid <= 1'b1;
    in_w.mode <= mode;
    in_w.item_start <= qs;
    in_w.item_end <= qe;
    base = pending_results.size();
    predict_join(mode, qs, qe);
    if (pending_results.size() > base) predicted_first = pending_results[base];
    words_in++;
    do @(posedge clk_i); while (!in_w.ready);
  endtask

  task automatic wait_drained();
    in_w.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_random_word(int unsigned span);
    logic [CBITS-1:0] s;
    logic [CBITS-1:0] e;
    int unsigned pick;
    pick = $urandom_range(99);
    s = CBITS'($urandom_range(span));
    e = s + CBITS'($urandom_range(span / 4));
    if ($urandom_range(19) == 0) begin
      s = CBITS'($urandom);
      e = CBITS'($urandom);
    end
    if (pick < 45) send_word(ioj_pkg::MODE_LOAD, s, e);
    else if (pick < 92) send_word(ioj_pkg::MODE_QUERY, s, e);
    else if (pick < 96) send_word(ioj_pkg::MODE_CLEAR, s, e);
    else send_word(ioj_pkg::MODE_NONE, s, e);
  endtask

  // Output side: random stalls, plus one long hold-off.
  initial begin
    out_w.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_w.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      out_w.ready <= !(out_idle_on && $urandom_range(99) < 21);
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_w.valid && out_w.ready) begin
      words_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word status=%0d index=%0d last=%0d", $time,
                 out_w.status, out_w.match_index, out_w.last);
        errors++;
      end else begin
        if (out_w.status !== pending_results[0].status ||
            out_w.match_index !== pending_results[0].index ||
            out_w.last !== pending_results[0].last) begin
          $display("%0t: expected status=%0d index=%0d last=%0d, got %0d %0d %0d", $time,
                   pending_results[0].status, pending_results[0].index,
                   pending_results[0].last, out_w.status, out_w.match_index, out_w.last);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("interval_overlap_join: mismatch");
      $finish;
    end
  end

  // Directed table, typed expectations checked against the predictor's first on the first pass.
  row_t directed[] = '{
    '{ioj_pkg::MODE_QUERY, 30'd0, 30'd100, 1'b1, '{ioj_pkg::ST_NOMATCH, 6'd0, 1'b1}},
    '{ioj_pkg::MODE_LOAD, 30'd10, 30'd50, 1'b1, '{ioj_pkg::ST_LOADED, 6'd0, 1'b1}},
    '{ioj_pkg::MODE_LOAD, 30'd5, 30'd60, 1'b1, '{ioj_pkg::ST_LOADED, 6'd0, 1'b1}},
    '{ioj_pkg::MODE_LOAD, 30'd10, 30'd20, 1'b1, '{ioj_pkg::ST_LOADED, 6'd0, 1'b1}},
    '{ioj_pkg::MODE_LOAD, 30'h3FFFFFFF, 30'h3FFFFFFF, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_LOAD, 30'd0, 30'h3FFFFFFF, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_LOAD, 30'd40, 30'd30, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_QUERY, 30'd0, 30'd100, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_QUERY, 30'd15, 30'd45, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_QUERY, 30'd35, 30'd35, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_QUERY, 30'd90, 30'd10, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_QUERY, 30'h3FFFFFFF, 30'h3FFFFFFF, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_QUERY, 30'd0, 30'h3FFFFFFF, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_NONE, 30'h2AAAAAAA, 30'h15555555, 1'b0, '{default: '0}},
    '{ioj_pkg::MODE_CLEAR, 30'h15555555, 30'h2AAAAAAA, 1'b1,
      '{ioj_pkg::ST_CLEARED, 6'd0, 1'b1}},
    '{ioj_pkg::MODE_QUERY, 30'd0, 30'h3FFFFFFF, 1'b1, '{ioj_pkg::ST_NOMATCH, 6'd0, 1'b1}}
  };

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ioj_pkg::REG_MATCH_MODE;
    cfg_data_i = '0;
    in_w.valid = 1'b0;
    in_w.mode = ioj_pkg::MODE_NONE;
    in_w.item_start = '0;
    in_w.item_end = '0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    match_words = 0;
    full_hits = 0;
    idle_cycles = 0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    long_hold = 1'b0;
    tbl_count = 0;
    sh_any_mode = 1'b0;
    sh_qon = 1'b1;
    sh_son = 1'b1;
    sh_qrate = 18'd32768;
    sh_srate = 18'd32768;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset settings, then again in any-overlap mode.
    for (int pass = 0; pass < 2; pass++) begin
      foreach (directed[r]) begin
        send_word(directed[r].mode, directed[r].qs, directed[r].qe);
        if (directed[r].typed && pass == 0) begin
          if (predicted_first !== directed[r].want) begin
            $display("%0t: row %0d expected %p, predicted %p", $time, r,
                     directed[r].want, predicted_first);
            errors++;
          end
        end
      end
      wait_drained();
      write_reg(ioj_pkg::REG_MATCH_MODE, 18'd1);
    end

    // Fill the table to the top and overflow it, with the receiver held off.
    long_hold = 1'b1;
    repeat (DEPTH + 2) send_word(ioj_pkg::MODE_LOAD, CBITS'($urandom_range(200)),
                                  CBITS'($urandom_range(400)));
    send_word(ioj_pkg::MODE_QUERY, 30'd0, 30'h3FFFFFFF);
    wait_drained();

    // Random phases across the rate settings, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(ioj_pkg::REG_MATCH_MODE, 18'(phase == 5));
      write_reg(ioj_pkg::REG_QUERY_RATE_ON, 18'(phase != 2));
      write_reg(ioj_pkg::REG_SUBJECT_RATE_ON, 18'(phase != 3 && phase != 4));
      write_reg(ioj_pkg::REG_QUERY_RATE, phase == 0 ? 18'd0 : phase == 1 ? 18'h3FFFF :
                                phase == 4 ? 18'd131072 : 18'($urandom));
      write_reg(ioj_pkg::REG_SUBJECT_RATE, phase == 0 ? 18'h3FFFF : phase == 1 ? 18'd0 :
                                  18'($urandom_range(131072)));
      if (phase == 4) write_reg(ioj_pkg::REG_QUERY_RATE_ON, 18'd0);
      in_idle_on = (phase != 2);
      out_idle_on = (phase != 2);
      send_word(ioj_pkg::MODE_CLEAR, CBITS'($urandom), CBITS'($urandom));
      repeat (RANDOM_ITEMS / 6) send_random_word(phase == 1 ? 1000 : 300);
      wait_drained();
    end

    $display("Sent %0d words, checked %0d result words (%0d matches, %0d full-table loads).",
             words_in, words_out, match_words, full_hits);
    if (errors == 0) begin
      $display("interval_overlap_join: match");
    end else begin
      $display("interval_overlap_join: mismatch");
    end
    $finish;
  end

endmodule
